@@ rtl/swser_pkg.sv @@
// ----------------------------------------------------------------------------
// swser_pkg: shared types and constants
// Widths, window limits and queue sizing for the sliding-window symbol
// error rate block.
// ----------------------------------------------------------------------------
package swser_pkg;

    localparam int SYM_W      = 8;
    localparam int MAX_WINDOW = 65536;
    localparam int POS_W      = $clog2(MAX_WINDOW);
    localparam int WIN_W      = POS_W + 1;
    localparam int CNT_W      = WIN_W;
    localparam int RATE_FRAC  = 16;
    localparam int RATE_W     = RATE_FRAC + 1;
    localparam int REM_W      = POS_W;
    localparam int DIV_STAGES = RATE_FRAC + 1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_LW    = FIFO_AW + 1;

    typedef logic [SYM_W-1:0]   t_sym;
    typedef logic [WIN_W-1:0]   t_window;
    typedef logic [CNT_W-1:0]   t_count;
    typedef logic [RATE_W-1:0]  t_rate;
    typedef logic [POS_W-1:0]   t_pos;
    typedef logic [REM_W-1:0]   t_rem;
    typedef logic [FIFO_LW-1:0] t_level;

    // Handshake between the queue and the divider pipeline.
    typedef struct packed {
        logic   valid;
        t_count count;
    } t_head;

    localparam t_window WINDOW_MAX = WIN_W'(MAX_WINDOW);
    localparam t_window WINDOW_MIN = WIN_W'(1);

    function automatic t_window clamp_window(input t_window v);
        t_window w;
        w = v;
        if (v == '0) begin
            w = WINDOW_MIN;
        end else if (v > WINDOW_MAX) begin
            w = WINDOW_MAX;
        end
        return w;
    endfunction

endpackage

@@ rtl/swser_front.sv @@
// ----------------------------------------------------------------------------
// swser_front: symbol compare and mismatch ring
// Compares each symbol pair, keeps the mismatch ring in a memory and updates
// the running error count, then hands the count to the queue.
// ----------------------------------------------------------------------------
module swser_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clear,
    input  swser_pkg::t_window i_window,
    input  logic               push,
    output logic               full,
    input  swser_pkg::t_sym    i_symbol_received,
    input  swser_pkg::t_sym    i_symbol_reference,
    input  swser_pkg::t_level  i_fifo_level,
    output logic               o_push,
    output swser_pkg::t_count  o_count
);

    logic                 r_mem [swser_pkg::MAX_WINDOW];
    logic                 r_rd;

    swser_pkg::t_pos      r_pos;
    logic                 r_wrapped;
    swser_pkg::t_count    r_count;

    logic                 r_s_valid;
    logic                 r_s_miss;
    swser_pkg::t_pos      r_s_pos;
    logic                 r_s_wrapped;
    logic                 r_s_fwd;
    logic                 r_s_fwd_miss;

    logic                 accept;
    logic                 miss;
    logic [swser_pkg::WIN_W-1:0] pos_inc;
    logic                 old_bit;
    logic                 dec;
    swser_pkg::t_count    n_count;
    logic [swser_pkg::FIFO_LW:0] occupancy;

    // Reserve a queue slot for the word still in the compare stage.
    assign occupancy = {1'b0, i_fifo_level} + (swser_pkg::FIFO_LW + 1)'(r_s_valid);
    assign full      = occupancy >= (swser_pkg::FIFO_LW + 1)'(swser_pkg::FIFO_DEPTH);
    assign accept    = push && !full;
    assign miss      = i_symbol_received != i_symbol_reference;
    assign pos_inc   = {1'b0, r_pos} + swser_pkg::WIN_W'(1);

    // Entries not yet written since the last clear read as matches. A word
    // that rereads the entry written in the same cycle takes the forwarded bit.
    assign old_bit = r_s_fwd ? r_s_fwd_miss : (r_s_wrapped && r_rd);
    assign dec     = old_bit && (r_count != '0);
    assign n_count = r_count - swser_pkg::CNT_W'(dec) + swser_pkg::CNT_W'(r_s_miss);

    assign o_push  = r_s_valid;
    assign o_count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_wrapped <= 1'b0;
            r_count   <= '0;
            r_s_valid <= 1'b0;
        end else if (i_clear) begin
            r_pos     <= '0;
            r_wrapped <= 1'b0;
            r_count   <= '0;
            r_s_valid <= 1'b0;
        end else begin
            r_s_valid <= accept;
            if (accept) begin
                if (pos_inc >= i_window) begin
                    r_pos     <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_pos <= pos_inc[swser_pkg::POS_W-1:0];
                end
            end
            if (r_s_valid) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s_miss     <= miss;
            r_s_pos      <= r_pos;
            r_s_wrapped  <= r_wrapped;
            r_s_fwd      <= r_s_valid && (r_s_pos == r_pos);
            r_s_fwd_miss <= r_s_miss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= r_mem[r_pos];
        end
        if (r_s_valid) begin
            r_mem[r_s_pos] <= r_s_miss;
        end
    end

endmodule

@@ rtl/swser_fifo.sv @@
// ----------------------------------------------------------------------------
// swser_fifo: count queue
// Short queue that decouples the compare stage from the divider pipeline.
// ----------------------------------------------------------------------------
module swser_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  logic              i_push,
    input  swser_pkg::t_count i_count,
    input  logic              i_pop,
    output swser_pkg::t_head  o_head,
    output swser_pkg::t_level o_level
);

    swser_pkg::t_count             r_mem [swser_pkg::FIFO_DEPTH];
    logic [swser_pkg::FIFO_AW-1:0] r_wr;
    logic [swser_pkg::FIFO_AW-1:0] r_rd;
    swser_pkg::t_level             r_level;

    logic do_pop;

    assign do_pop       = i_pop && (r_level != '0);
    assign o_head.valid = r_level != '0;
    assign o_head.count = r_mem[r_rd];
    assign o_level      = r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else if (i_clear) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + swser_pkg::FIFO_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + swser_pkg::FIFO_AW'(1);
            end
            r_level <= r_level + swser_pkg::FIFO_LW'(i_push)
                               - swser_pkg::FIFO_LW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_count;
        end
    end

endmodule

@@ rtl/swser_back.sv @@
// ----------------------------------------------------------------------------
// swser_back: error rate divider pipeline
// Pipelined restoring division of count * 2^16 by the window length, one
// quotient bit per stage. The last stage is the result register.
// ----------------------------------------------------------------------------
module swser_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swser_pkg::t_window i_window,
    input  swser_pkg::t_head   i_head,
    output logic               o_take,
    output logic               empty,
    input  logic               pop,
    output swser_pkg::t_count  o_error_count,
    output swser_pkg::t_rate   o_error_rate
);

    localparam int LAST = swser_pkg::DIV_STAGES - 1;

    logic              r_v   [swser_pkg::DIV_STAGES];
    swser_pkg::t_rem   r_rem [swser_pkg::DIV_STAGES];
    swser_pkg::t_rate  r_q   [swser_pkg::DIV_STAGES];
    swser_pkg::t_count r_cnt [swser_pkg::DIV_STAGES];

    swser_pkg::t_rem   n_rem [swser_pkg::DIV_STAGES];
    swser_pkg::t_rate  n_q   [swser_pkg::DIV_STAGES];
    logic [swser_pkg::REM_W:0] dbl [swser_pkg::DIV_STAGES];

    logic en;
    logic hit;

    // The whole pipeline holds while a finished word waits to be taken.
    assign en     = !r_v[LAST] || pop;
    assign o_take = en && i_head.valid;
    assign empty  = !r_v[LAST];

    assign o_error_count = r_cnt[LAST];
    assign o_error_rate  = r_q[LAST];

    // The count never exceeds the window, so the top quotient bit is set
    // only when they are equal, and the remainder then fits in 16 bits.
    assign hit = i_head.count >= i_window;

    always_comb begin
        n_rem[0] = hit ? '0 : i_head.count[swser_pkg::REM_W-1:0];
        n_q[0]   = hit ? swser_pkg::RATE_W'(1) << swser_pkg::RATE_FRAC : '0;
        dbl[0]   = '0;
        for (int k = 1; k < swser_pkg::DIV_STAGES; k++) begin
            dbl[k]   = {r_rem[k-1], 1'b0};
            n_rem[k] = r_rem[k-1];
            n_q[k]   = r_q[k-1];
            if (dbl[k] >= i_window) begin
                n_rem[k] = swser_pkg::REM_W'(dbl[k] - i_window);
                n_q[k][swser_pkg::RATE_FRAC-k] = 1'b1;
            end else begin
                n_rem[k] = dbl[k][swser_pkg::REM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < swser_pkg::DIV_STAGES; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= i_head.valid;
            for (int k = 1; k < swser_pkg::DIV_STAGES; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[0] <= n_rem[0];
            r_q[0]   <= n_q[0];
            r_cnt[0] <= i_head.count;
            for (int k = 1; k < swser_pkg::DIV_STAGES; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                r_cnt[k] <= r_cnt[k-1];
            end
        end
    end

endmodule

@@ rtl/sliding_window_symbol_error_rate.sv @@
// ----------------------------------------------------------------------------
// sliding_window_symbol_error_rate: windowed symbol error counter
// Counts symbol mismatches over the last window_length compares and reports
// the count together with count * 2^16 / window_length for every pair.
//
// Input words (a received and a reference symbol) are pushed with push while
// full is low. Each word yields one result word, popped with pop while empty
// is low, oldest first. The window length is written on the cfg channel,
// which is always ready; a write clears the ring and the count. The user
// makes a write only while no word is in flight; the block does not enforce it.
// A word passes one ring read stage, one queue stage and 17 divider stages,
// one quotient bit each, to the result on the outputs. Throughput is one
// word per cycle while pop keeps up with the results, set by the ring memory's
// separate read and write ports and the fully pipelined divider.
// A stalled pop freezes the divider pipeline; the four-entry queue then
// fills and full rises, so no word is lost. After reset the window is 65536,
// the count is zero and all ring entries count as matches; words are taken
// as soon as reset is released.
// ----------------------------------------------------------------------------
module sliding_window_symbol_error_rate (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  swser_pkg::t_window  i_cfg_window_length,
    input  logic                push,
    output logic                full,
    input  swser_pkg::t_sym     i_symbol_received,
    input  swser_pkg::t_sym     i_symbol_reference,
    output logic                empty,
    input  logic                pop,
    output swser_pkg::t_count   o_error_count,
    output swser_pkg::t_rate    o_error_rate
);

    swser_pkg::t_window r_window;
    swser_pkg::t_window n_window;

    logic              cfg_write;
    logic              fr_push;
    swser_pkg::t_count fr_count;
    swser_pkg::t_level fifo_level;
    swser_pkg::t_head  fifo_head;
    logic              back_take;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign n_window    = swser_pkg::clamp_window(i_cfg_window_length);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= swser_pkg::WINDOW_MAX;
        end else if (cfg_write) begin
            r_window <= n_window;
        end
    end

    swser_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_clear            (cfg_write),
        .i_window           (r_window),
        .push               (push),
        .full               (full),
        .i_symbol_received  (i_symbol_received),
        .i_symbol_reference (i_symbol_reference),
        .i_fifo_level       (fifo_level),
        .o_push             (fr_push),
        .o_count            (fr_count)
    );

    swser_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (cfg_write),
        .i_push  (fr_push),
        .i_count (fr_count),
        .i_pop   (back_take),
        .o_head  (fifo_head),
        .o_level (fifo_level)
    );

    swser_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_window      (r_window),
        .i_head        (fifo_head),
        .o_take        (back_take),
        .empty         (empty),
        .pop           (pop),
        .o_error_count (o_error_count),
        .o_error_rate  (o_error_rate)
    );

endmodule
